### rtl/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer package
// Shared codes, command tables, result record and helper functions.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES_DEF = 512;
  localparam int WAKE_BYTES_DEF  = 10;
  localparam int OUTQ_DEPTH      = 4;
  localparam int CFG_ADDR_W      = 3;

  localparam logic [7:0] POLL_LIMIT_RST    = 8'd10;
  localparam logic [7:0] INIT_ATTEMPTS_RST = 8'd10;

  localparam logic REG_POLL_LIMIT    = 1'b0;
  localparam logic REG_INIT_ATTEMPTS = 1'b1;

  localparam logic [1:0] ACT_INIT = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_XCHG = 2'd2;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_R1_ERR    = 2'd1;
  localparam logic [1:0] ST_TOKEN_ERR = 2'd2;

  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [7:0]  TOKEN_START = 8'hFE;
  localparam logic [7:0]  R1_READY    = 8'h00;
  localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
  localparam int          OCR_CCS_BIT = 30;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_WAKE,
    PH_SEND,
    PH_POLL,
    PH_EXTRA,
    PH_TRAIL,
    PH_TOKEN,
    PH_DATA,
    PH_CRC,
    PH_END_OK,
    PH_END_R1,
    PH_END_TOKEN
  } phase_t;

  typedef enum logic [2:0] {
    STEP_CMD0,
    STEP_CMD8,
    STEP_CMD58A,
    STEP_CMD55,
    STEP_CMD41,
    STEP_CMD58B,
    STEP_CMD16,
    STEP_READ
  } step_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       slow_clock;
    logic [7:0] data_byte;
    logic [8:0] byte_index;
    logic [1:0] status;
    logic [7:0] response_code;
    logic       high_capacity;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [7:0] poll_limit;
    logic [7:0] init_attempts;
  } cfg_t;

  function automatic logic [7:0] at_least_one(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  function automatic logic [5:0] cmd_index(input step_t s);
    logic [5:0] c;
    unique case (s)
      STEP_CMD0:   c = 6'd0;
      STEP_CMD8:   c = 6'd8;
      STEP_CMD58A: c = 6'd58;
      STEP_CMD55:  c = 6'd55;
      STEP_CMD41:  c = 6'd41;
      STEP_CMD58B: c = 6'd58;
      STEP_CMD16:  c = 6'd16;
      STEP_READ:   c = 6'd17;
      default:     c = 6'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cmd_crc(input step_t s);
    logic [7:0] c;
    unique case (s)
      STEP_CMD0:  c = 8'h95;
      STEP_CMD8:  c = 8'h87;
      STEP_CMD55: c = 8'h65;
      STEP_CMD41: c = 8'hE5;
      default:    c = 8'h01;
    endcase
    return c;
  endfunction

  function automatic logic cmd_long(input step_t s);
    return (s == STEP_CMD8) || (s == STEP_CMD58A) || (s == STEP_CMD58B);
  endfunction

  function automatic logic [7:0] frame_byte(input step_t s, input logic [2:0] k,
                                            input logic [31:0] arg);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = {2'b01, cmd_index(s)};
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = cmd_crc(s);
    endcase
    return b;
  endfunction

  function automatic res_t mk_tx(input logic [7:0] tx, input logic sel, input logic slow,
                                 input logic hc);
    res_t r;
    r               = '0;
    r.kind          = KIND_TX;
    r.tx_byte       = tx;
    r.select_active = sel;
    r.slow_clock    = slow;
    r.high_capacity = hc;
    return r;
  endfunction

  function automatic res_t mk_data(input logic [7:0] d, input logic [8:0] idx,
                                   input logic slow, input logic hc);
    res_t r;
    r               = '0;
    r.kind          = KIND_DATA;
    r.data_byte     = d;
    r.byte_index    = idx;
    r.slow_clock    = slow;
    r.high_capacity = hc;
    return r;
  endfunction

  function automatic res_t mk_done(input logic [1:0] st, input logic [7:0] code,
                                   input logic slow, input logic hc);
    res_t r;
    r               = '0;
    r.kind          = KIND_DONE;
    r.status        = st;
    r.response_code = code;
    r.slow_clock    = slow;
    r.high_capacity = hc;
    return r;
  endfunction

endpackage

### rtl/sdspi_regs.sv
// ----------------------------------------------------------------------------
// SD card SPI host configuration registers
// APB-style register bank holding the poll limit and init attempt count.
// ----------------------------------------------------------------------------
module sdspi_regs
  import sdspi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poll_limit    <= POLL_LIMIT_RST;
      cfg_r.init_attempts <= INIT_ATTEMPTS_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_POLL_LIMIT) begin
        cfg_r.poll_limit <= pwdata[7:0];
      end else begin
        cfg_r.init_attempts <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'd0, (paddr[2] == REG_INIT_ATTEMPTS) ? cfg_r.init_attempts
                                                          : cfg_r.poll_limit};
  assign cfg    = cfg_r;

endmodule

### rtl/sdspi_seq.sv
// ----------------------------------------------------------------------------
// SD card SPI host command sequencer
// Input register and the init, command and block read state machine.
// ----------------------------------------------------------------------------
module sdspi_seq
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int WAKE_BYTES  = WAKE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_block_number,
  input  logic [7:0]  in_rx_byte,
  input  cfg_t        cfg,
  input  logic        room,
  output logic [1:0]  res_n,
  output res_t        res_a,
  output res_t        res_b
);

  localparam int CNT_MAX = (BLOCK_BYTES > WAKE_BYTES) ? BLOCK_BYTES : WAKE_BYTES;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam logic [CNT_W-1:0] BLOCK_CNT  = CNT_W'(BLOCK_BYTES);
  localparam logic [CNT_W-1:0] WAKE_CNT   = CNT_W'(WAKE_BYTES);
  localparam logic [CNT_W-1:0] FRAME_CNT  = CNT_W'(5);
  localparam logic [CNT_W-1:0] EXTRA_CNT  = CNT_W'(4);
  localparam logic [CNT_W-1:0] CRC_CNT    = CNT_W'(2);
  localparam logic [31:0]      BLOCK_MUL  = 32'(BLOCK_BYTES);

  logic        in_vld_r;
  logic [1:0]  act_r;
  logic [31:0] blk_r;
  logic [7:0]  rx_r;
  logic        fire;
  logic        acc;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]       poll_r, poll_nxt;
  logic [7:0]       att_r, att_nxt;
  step_t            step_r, step_nxt;
  logic [31:0]      arg_r, arg_nxt;
  logic [31:0]      ocr_r, ocr_nxt;
  logic [7:0]       last_r, last_nxt;
  logic             cap_r, cap_nxt;
  logic             slow_r, slow_nxt;

  logic [7:0]  eff_poll;
  logic [7:0]  eff_att;
  logic [31:0] arg_scaled;
  logic [31:0] cmd_arg;
  logic [7:0]  frame_tx;
  logic        tx_sel;

  assign fire     = in_vld_r & room;
  assign in_stall = in_vld_r & ~room;
  assign acc      = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= acc | (in_vld_r & ~fire);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      act_r <= in_action;
      blk_r <= in_block_number;
      rx_r  <= in_rx_byte;
    end
  end

  assign eff_poll   = at_least_one(cfg.poll_limit);
  assign eff_att    = at_least_one(cfg.init_attempts);
  assign arg_scaled = blk_r * BLOCK_MUL;
  assign cnt_inc    = cnt_r + CNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    poll_nxt  = poll_r;
    att_nxt   = att_r;
    step_nxt  = step_r;
    arg_nxt   = arg_r;
    ocr_nxt   = ocr_r;
    last_nxt  = last_r;
    cap_nxt   = cap_r;
    slow_nxt  = slow_r;
    unique case (act_r)
      ACT_INIT: begin
        if (phase_r == PH_IDLE) begin
          cap_nxt   = 1'b0;
          slow_nxt  = 1'b1;
          phase_nxt = PH_WAKE;
          cnt_nxt   = '0;
        end
      end
      ACT_READ: begin
        if (phase_r == PH_IDLE) begin
          arg_nxt   = cap_r ? blk_r : arg_scaled;
          step_nxt  = STEP_READ;
          cnt_nxt   = '0;
          phase_nxt = PH_SEND;
        end
      end
      ACT_XCHG: begin
        unique case (phase_r)
          PH_WAKE: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= WAKE_CNT) begin
              step_nxt  = STEP_CMD0;
              cnt_nxt   = '0;
              phase_nxt = PH_SEND;
            end
          end
          PH_SEND: begin
            if (cnt_r < FRAME_CNT) begin
              cnt_nxt = cnt_inc;
            end else begin
              phase_nxt = PH_POLL;
              poll_nxt  = 8'd1;
              last_nxt  = FILL_BYTE;
            end
          end
          PH_POLL: begin
            last_nxt = rx_r;
            if (rx_r == FILL_BYTE && poll_r < eff_poll) begin
              poll_nxt = poll_r + 8'd1;
            end else if (step_r == STEP_READ) begin
              if (rx_r == R1_READY) begin
                phase_nxt = PH_TOKEN;
                poll_nxt  = 8'd1;
              end else begin
                phase_nxt = PH_END_R1;
              end
            end else if (rx_r != FILL_BYTE && cmd_long(step_r)) begin
              phase_nxt = PH_EXTRA;
              cnt_nxt   = '0;
            end else begin
              phase_nxt = PH_TRAIL;
            end
          end
          PH_EXTRA: begin
            ocr_nxt = {ocr_r[23:0], rx_r};
            cnt_nxt = cnt_inc;
            if (cnt_inc >= EXTRA_CNT) begin
              phase_nxt = PH_TRAIL;
            end
          end
          PH_TRAIL: begin
            cnt_nxt   = '0;
            phase_nxt = PH_SEND;
            unique case (step_r)
              STEP_CMD0:   step_nxt = STEP_CMD8;
              STEP_CMD8:   step_nxt = STEP_CMD58A;
              STEP_CMD58A: begin
                att_nxt  = 8'd1;
                step_nxt = STEP_CMD55;
              end
              STEP_CMD55:  step_nxt = STEP_CMD41;
              STEP_CMD41: begin
                if (last_r == R1_READY || att_r >= eff_att) begin
                  step_nxt = STEP_CMD58B;
                end else begin
                  att_nxt  = att_r + 8'd1;
                  step_nxt = STEP_CMD55;
                end
              end
              STEP_CMD58B: begin
                cap_nxt  = ocr_r[OCR_CCS_BIT];
                step_nxt = STEP_CMD16;
              end
              STEP_CMD16: begin
                slow_nxt  = 1'b0;
                cnt_nxt   = cnt_r;
                phase_nxt = PH_IDLE;
              end
              default: begin
                cnt_nxt   = cnt_r;
                phase_nxt = PH_IDLE;
              end
            endcase
          end
          PH_TOKEN: begin
            last_nxt = rx_r;
            if (rx_r == TOKEN_START) begin
              phase_nxt = PH_DATA;
              cnt_nxt   = '0;
            end else if (poll_r >= eff_poll) begin
              phase_nxt = PH_END_TOKEN;
            end else begin
              poll_nxt = poll_r + 8'd1;
            end
          end
          PH_DATA: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= BLOCK_CNT) begin
              phase_nxt = PH_CRC;
              cnt_nxt   = '0;
            end
          end
          PH_CRC: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= CRC_CNT) begin
              phase_nxt = PH_END_OK;
            end
          end
          PH_END_OK, PH_END_R1, PH_END_TOKEN: phase_nxt = PH_IDLE;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (step_nxt)
      STEP_READ:  cmd_arg = arg_nxt;
      STEP_CMD8:  cmd_arg = CMD8_ARG;
      STEP_CMD16: cmd_arg = BLOCK_MUL;
      default:    cmd_arg = '0;
    endcase
  end

  assign frame_tx = frame_byte(step_nxt, cnt_nxt[2:0], cmd_arg);
  assign tx_sel   = ~(phase_nxt == PH_END_R1 || phase_nxt == PH_TRAIL ||
                      phase_nxt == PH_END_TOKEN || phase_nxt == PH_END_OK);

  always_comb begin
    res_n = 2'd0;
    res_a = '0;
    res_b = '0;
    if (fire) begin
      unique case (act_r)
        ACT_INIT: begin
          if (phase_r == PH_IDLE) begin
            res_n = 2'd1;
            res_a = mk_tx(FILL_BYTE, 1'b0, slow_nxt, cap_nxt);
          end
        end
        ACT_READ: begin
          if (phase_r == PH_IDLE) begin
            res_n = 2'd1;
            res_a = mk_tx(frame_tx, 1'b1, slow_nxt, cap_nxt);
          end
        end
        ACT_XCHG: begin
          if (phase_r != PH_IDLE) begin
            res_n = 2'd1;
            unique case (phase_r)
              PH_DATA: begin
                res_n = 2'd2;
                res_a = mk_data(rx_r, 9'(cnt_r), slow_nxt, cap_nxt);
                res_b = mk_tx(FILL_BYTE, 1'b1, slow_nxt, cap_nxt);
              end
              PH_END_OK:    res_a = mk_done(ST_OK, 8'h00, slow_nxt, cap_nxt);
              PH_END_R1:    res_a = mk_done(ST_R1_ERR, last_r, slow_nxt, cap_nxt);
              PH_END_TOKEN: res_a = mk_done(ST_TOKEN_ERR, last_r, slow_nxt, cap_nxt);
              PH_TRAIL: begin
                if (phase_nxt == PH_IDLE) begin
                  res_a = mk_done(ST_OK, 8'h00, slow_nxt, cap_nxt);
                end else begin
                  res_a = mk_tx(frame_tx, 1'b1, slow_nxt, cap_nxt);
                end
              end
              PH_WAKE: begin
                if (phase_nxt == PH_SEND) begin
                  res_a = mk_tx(frame_tx, 1'b1, slow_nxt, cap_nxt);
                end else begin
                  res_a = mk_tx(FILL_BYTE, 1'b0, slow_nxt, cap_nxt);
                end
              end
              PH_SEND: begin
                if (phase_nxt == PH_SEND) begin
                  res_a = mk_tx(frame_tx, 1'b1, slow_nxt, cap_nxt);
                end else begin
                  res_a = mk_tx(FILL_BYTE, 1'b1, slow_nxt, cap_nxt);
                end
              end
              default: res_a = mk_tx(FILL_BYTE, tx_sel, slow_nxt, cap_nxt);
            endcase
          end
        end
        default: ;
      endcase
      if (res_n == 2'd1) begin
        res_a.last = 1'b1;
      end
      if (res_n == 2'd2) begin
        res_b.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      poll_r  <= '0;
      att_r   <= '0;
      step_r  <= STEP_CMD0;
      arg_r   <= '0;
      ocr_r   <= '0;
      last_r  <= FILL_BYTE;
      cap_r   <= 1'b0;
      slow_r  <= 1'b1;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      poll_r  <= poll_nxt;
      att_r   <= att_nxt;
      step_r  <= step_nxt;
      arg_r   <= arg_nxt;
      ocr_r   <= ocr_nxt;
      last_r  <= last_nxt;
      cap_r   <= cap_nxt;
      slow_r  <= slow_nxt;
    end
  end

endmodule

### rtl/sdspi_outq.sv
// ----------------------------------------------------------------------------
// SD card SPI host result queue
// Small queue: takes up to two results a cycle, hands out one unless stalled.
// ----------------------------------------------------------------------------
module sdspi_outq
  import sdspi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  res_t       push_a,
  input  res_t       push_b,
  output logic       room,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_res
);

  localparam int PTR_W = $clog2(OUTQ_DEPTH);

  localparam logic [PTR_W:0] ROOM_MAX = (PTR_W + 1)'(OUTQ_DEPTH - 2);

  res_t             mem [OUTQ_DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [PTR_W:0]   count_r;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid & ~out_stall;
  assign room      = (count_r <= ROOM_MAX);
  assign out_res   = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + PTR_W'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_r + PTR_W'(push_n);
      rp_r    <= rp_r + PTR_W'(pop);
      count_r <= count_r + (PTR_W + 1)'(push_n) - (PTR_W + 1)'(pop);
    end
  end

endmodule

### rtl/sd_card_spi_host_sequencer.sv
// ----------------------------------------------------------------------------
// SD card SPI host sequencer
// A result passes the input register, then the result queue, before it is
// offered. Throughput: one input transaction per cycle while in_stall is low;
// the single result port moves one result per cycle while out_stall is low,
// and a data byte transaction gives two results.
// Reset: synchronous; idle, slow clock, standard capacity, limits set to 10.
// ----------------------------------------------------------------------------
module sd_card_spi_host_sequencer
  import sdspi_pkg::*;
#(
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  parameter int WAKE_BYTES  = WAKE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_action,
  input  logic [31:0]           in_block_number,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_tx_byte,
  output logic                  out_select_active,
  output logic                  out_slow_clock,
  output logic [7:0]            out_data_byte,
  output logic [8:0]            out_byte_index,
  output logic [1:0]            out_status,
  output logic [7:0]            out_response_code,
  output logic                  out_high_capacity,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t       cfg;
  logic       room;
  logic [1:0] res_n;
  res_t       res_a;
  res_t       res_b;
  res_t       out_res;

  sdspi_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdspi_seq #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .WAKE_BYTES  (WAKE_BYTES)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_block_number (in_block_number),
    .in_rx_byte      (in_rx_byte),
    .cfg             (cfg),
    .room            (room),
    .res_n           (res_n),
    .res_a           (res_a),
    .res_b           (res_b)
  );

  sdspi_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (res_n),
    .push_a    (res_a),
    .push_b    (res_b),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_tx_byte       = out_res.tx_byte;
  assign out_select_active = out_res.select_active;
  assign out_slow_clock    = out_res.slow_clock;
  assign out_data_byte     = out_res.data_byte;
  assign out_byte_index    = out_res.byte_index;
  assign out_status        = out_res.status;
  assign out_response_code = out_res.response_code;
  assign out_high_capacity = out_res.high_capacity;
  assign out_last          = out_res.last;

`ifndef SYNTHESIS
  a_pair_is_data_then_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (res_n == 2'd2) |-> (res_a.kind == KIND_DATA && res_b.kind == KIND_TX && !res_a.last))
    else $error("two results from one transaction must be a data byte then a transmit");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DONE) |-> (out_last && !out_select_active))
    else $error("finished result must be last and deselected");

  a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_kind == KIND_DONE))
    else $error("error status on a result that is not a finish");

  a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_DATA) |-> !out_last)
    else $error("data byte result marked last");
`endif

endmodule
